>>> rtl/core/krdt_pkg.sv
// Shared types, constants and helpers of the keyboard report differ with typematic repeat.
package krdt_pkg;

	localparam int MaxKeys = 6;
	localparam int Slots   = 6;
	localparam int NKey    = (MaxKeys < Slots) ? MaxKeys : Slots;
	localparam int QDepth  = 4;
	localparam int QPtrW   = $clog2(QDepth);
	localparam int QCntW   = $clog2(QDepth + 1);

	localparam logic [7:0] KeyCapsLock = 8'h39;
	localparam int         BitCaps     = 6;
	localparam logic       ActTick     = 1'b1;

	typedef enum logic [1:0] {
		REG_REPEAT_ENABLE = 2'd0,
		REG_INITIAL_DELAY = 2'd1,
		REG_MIN_INTERVAL  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		BK_IDLE,
		BK_PRESS
	} back_state_t;

	typedef struct packed {
		logic       action;
		logic [2:0] key_count;
		logic [7:0] key_0;
		logic [7:0] key_1;
		logic [7:0] key_2;
		logic [7:0] key_3;
		logic [7:0] key_4;
		logic [7:0] key_5;
	} in_item_t;

	typedef struct packed {
		logic [7:0] keycode;
		logic [6:0] modifier_mask;
		logic       caps_led;
		logic       is_repeat;
		logic       last_event;
	} out_item_t;

	typedef struct packed {
		logic       repeat_enable;
		logic [9:0] initial_delay;
		logic [9:0] min_interval;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic                   is_tick;
		logic [Slots-1:0]       rel_mask;
		logic [Slots-1:0][7:0]  rel_keys;
		logic [6:0]             rel_mods;
		logic [Slots-1:0]       new_mask;
		logic [Slots-1:0][7:0]  new_keys;
	} work_t;

	function automatic logic [6:0] mod_of(input logic [7:0] k);
		logic [6:0] m;
		case (k)
			8'hE1: m = 7'h01;
			8'hE5: m = 7'h02;
			8'hE2: m = 7'h04;
			8'hE6: m = 7'h08;
			8'hE0: m = 7'h10;
			8'hE4: m = 7'h20;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/core/krdt_front.sv
// Front end: accepts reports and ticks, diffs reports against the held key list.
module krdt_front import krdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output work_t    q_data
);

	localparam logic [2:0] NKeyW = 3'(NKey);

	logic [Slots-1:0][7:0] held_q;
	logic [2:0]            held_cnt_q;
	logic [Slots-1:0][7:0] now_keys;
	logic [Slots-1:0]      now_vld;
	logic [Slots-1:0]      held_vld;
	logic [Slots-1:0]      in_now;
	logic [Slots-1:0]      in_held;
	logic [2:0]            cnt;
	logic [6:0]            rel_mods;
	logic                  is_tick;

	assign is_tick  = (in_data.action == ActTick);
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign cnt      = (in_data.key_count > NKeyW) ? NKeyW : in_data.key_count;

	assign now_keys[0] = in_data.key_0;
	assign now_keys[1] = in_data.key_1;
	assign now_keys[2] = in_data.key_2;
	assign now_keys[3] = in_data.key_3;
	assign now_keys[4] = in_data.key_4;
	assign now_keys[5] = in_data.key_5;

	always_comb begin
		rel_mods = '0;
		for (int i = 0; i < Slots; i++) begin
			now_vld[i]  = (3'(i) < cnt);
			held_vld[i] = (3'(i) < held_cnt_q);
		end
		for (int i = 0; i < Slots; i++) begin
			in_now[i]  = 1'b0;
			in_held[i] = 1'b0;
			for (int j = 0; j < Slots; j++) begin
				if (now_vld[j] && now_keys[j] == held_q[i])
					in_now[i] = 1'b1;
				if (held_vld[j] && held_q[j] == now_keys[i])
					in_held[i] = 1'b1;
			end
		end
		for (int i = 0; i < Slots; i++) begin
			if (held_vld[i] && !in_now[i])
				rel_mods = rel_mods | mod_of(held_q[i]);
		end
	end

	always_comb begin
		q_data          = '0;
		q_data.is_tick  = is_tick;
		q_data.rel_keys = held_q;
		q_data.new_keys = now_keys;
		if (!is_tick) begin
			q_data.rel_mask = held_vld & ~in_now;
			q_data.new_mask = now_vld & ~in_held;
			q_data.rel_mods = rel_mods;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= '0;
		end else if (q_push && !is_tick) begin
			for (int i = 0; i < Slots; i++)
				held_q[i] <= now_vld[i] ? now_keys[i] : 8'h00;
			held_cnt_q <= cnt;
		end
	end

endmodule

>>> rtl/core/krdt_queue.sv
// Short FIFO of classified items between front and back.
module krdt_queue import krdt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output work_t head
);

	work_t             mem [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  cnt_q;

	assign full  = (cnt_q == QCntW'(QDepth));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");
`endif

endmodule

>>> rtl/core/krdt_back.sv
// Back end: modifier and typematic state, emits press and repeat events.
module krdt_back import krdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  work_t     head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	back_state_t           st_q, st_d;
	logic [6:0]            mods_q, mods_d;
	logic                  rpt_active_q, rpt_active_d;
	logic [7:0]            rpt_key_q, rpt_key_d;
	logic [9:0]            rpt_period_q, rpt_period_d;
	logic [9:0]            rpt_count_q, rpt_count_d;
	logic [Slots-1:0]      pend_mask_q, pend_mask_d;
	logic [Slots-1:0][7:0] pend_keys_q, pend_keys_d;
	logic                  out_valid_q, out_valid_d;
	out_item_t             out_q, out_d;

	logic                  can_emit;
	logic                  rel_hit;
	logic [Slots-1:0]      sel_oh;
	logic [7:0]            sel_key;
	logic [6:0]            sel_mod;
	logic [11:0]           per_x3;
	logic [9:0]            per_dec;
	logic [9:0]            per_next;
	logic [6:0]            press_mods;

	assign can_emit  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign per_x3   = 12'(rpt_period_q) * 12'd3;
	assign per_dec  = per_x3[11:2];
	assign per_next = (per_dec < cfg.min_interval) ? cfg.min_interval : per_dec;

	// lowest pending press goes first
	assign sel_oh  = pend_mask_q & (~pend_mask_q + Slots'(1));
	assign sel_mod = mod_of(sel_key);
	assign press_mods = (mods_q | sel_mod) ^ ((sel_key == KeyCapsLock) ? 7'h40 : 7'h00);

	always_comb begin
		sel_key = '0;
		rel_hit = 1'b0;
		for (int i = 0; i < Slots; i++) begin
			if (sel_oh[i])
				sel_key = sel_key | pend_keys_q[i];
			if (head.rel_mask[i] && head.rel_keys[i] == rpt_key_q)
				rel_hit = 1'b1;
		end
	end

	always_comb begin
		st_d         = st_q;
		mods_d       = mods_q;
		rpt_active_d = rpt_active_q;
		rpt_key_d    = rpt_key_q;
		rpt_period_d = rpt_period_q;
		rpt_count_d  = rpt_count_q;
		pend_mask_d  = pend_mask_q;
		pend_keys_d  = pend_keys_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_d        = out_q;
		q_pop        = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!q_empty && head.is_tick) begin
					if (can_emit) begin
						q_pop = 1'b1;
						if (rpt_active_q && cfg.repeat_enable) begin
							if (rpt_count_q <= 10'd1) begin
								rpt_period_d        = per_next;
								rpt_count_d         = per_next;
								out_valid_d         = 1'b1;
								out_d.keycode       = rpt_key_q;
								out_d.modifier_mask = mods_q;
								out_d.caps_led      = mods_q[BitCaps];
								out_d.is_repeat     = 1'b1;
								out_d.last_event    = 1'b1;
							end else begin
								rpt_count_d = rpt_count_q - 10'd1;
							end
						end
					end
				end else if (!q_empty) begin
					// apply releases, then hold the new presses for stepping
					q_pop       = 1'b1;
					mods_d      = mods_q & ~head.rel_mods;
					if (rpt_active_q && rel_hit)
						rpt_active_d = 1'b0;
					pend_mask_d = head.new_mask;
					pend_keys_d = head.new_keys;
					if (head.new_mask != '0)
						st_d = BK_PRESS;
				end
			end
			BK_PRESS: begin
				if (can_emit) begin
					mods_d      = press_mods;
					pend_mask_d = pend_mask_q & ~sel_oh;
					if (cfg.repeat_enable && sel_mod == 7'h00) begin
						rpt_active_d = 1'b1;
						rpt_key_d    = sel_key;
						rpt_period_d = cfg.initial_delay;
						rpt_count_d  = cfg.initial_delay;
					end
					out_valid_d         = 1'b1;
					out_d.keycode       = sel_key;
					out_d.modifier_mask = press_mods;
					out_d.caps_led      = press_mods[BitCaps];
					out_d.is_repeat     = 1'b0;
					out_d.last_event    = (pend_mask_d == '0);
					if (pend_mask_d == '0)
						st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= BK_IDLE;
			mods_q       <= '0;
			rpt_active_q <= 1'b0;
			rpt_key_q    <= '0;
			rpt_period_q <= '0;
			rpt_count_q  <= '0;
			pend_mask_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q         <= st_d;
			mods_q       <= mods_d;
			rpt_active_q <= rpt_active_d;
			rpt_key_q    <= rpt_key_d;
			rpt_period_q <= rpt_period_d;
			rpt_count_q  <= rpt_count_d;
			pend_mask_q  <= pend_mask_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_keys_q <= pend_keys_d;
		out_q       <= out_d;
	end

`ifndef SYNTH
	a_press_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_PRESS && can_emit) |=>
		$countones(pend_mask_q) == $countones($past(pend_mask_q)) - 1)
		else $error("press step did not retire exactly one key");
	a_repeat_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_repeat) |-> out_q.last_event)
		else $error("repeat beat not marked last");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_IDLE) |-> (pend_mask_q == '0))
		else $error("idle with pending presses");
`endif

endmodule

>>> rtl/core/keyboard_report_diff_typematic.sv
// Top level: configuration registers, front end, work queue and back end.
//
// Input channel (in_valid/in_ready/in_data) takes one beat per keyboard
// report (action 0) or per millisecond tick (action 1). Output channel
// (out_valid/out_ready/out_data) gives one beat per press or repeat event;
// last_event marks the final beat caused by an input. Inputs that cause no
// event give no beat.
// Config: cfg_wr_en with cfg_index and cfg_wdata writes repeat_enable (0),
// initial_delay (1) or min_interval (2); other indexes are ignored.
// Write only while the block is idle.
// Timing: the front diffs a report against the held keys in the accept
// cycle and queues it. The back pops a tick only when it can emit, a report
// also when stalled, and then steps through the new presses, one event per
// cycle while the output is not stalled. With an empty queue a repeat event
// passes the queue and output registers, a first press also the pending-press
// register. A four-entry queue lets the front keep accepting while the back steps through presses.
// Reset clears held keys, modifiers and repeat state and loads the register
// defaults 1, 250, 50. When out_ready is low the output register holds its
// beat, the back stops at a tick or press and in_ready drops on a full queue.
module keyboard_report_diff_typematic import krdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	work_t q_in;
	work_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_enable <= 1'b1;
			cfg_q.initial_delay <= 10'd250;
			cfg_q.min_interval  <= 10'd50;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_REPEAT_ENABLE: cfg_q.repeat_enable <= cfg_wdata[0];
				REG_INITIAL_DELAY: cfg_q.initial_delay <= cfg_wdata;
				REG_MIN_INTERVAL:  cfg_q.min_interval  <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	krdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	krdt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	krdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> bench/keyboard_report_diff_typematic_test.sv
// Self-checking testbench for keyboard_report_diff_typematic: predictor, scoreboard, stimulus.
package krdt_test_pkg;
	import krdt_pkg::*;

	localparam logic       ActReport = ~ActTick;
	localparam logic [7:0] KeyA      = 8'h04;
	localparam logic [7:0] KeyB      = 8'h05;
	localparam logic [7:0] KeyLCtrl  = 8'hE0;
	localparam logic [7:0] KeyLShift = 8'hE1;
	localparam logic [7:0] KeyLAlt   = 8'hE2;
	localparam logic [7:0] KeyLGui   = 8'hE3;
	localparam logic [7:0] KeyRCtrl  = 8'hE4;
	localparam logic [7:0] KeyRShift = 8'hE5;
	localparam logic [7:0] KeyRAlt   = 8'hE6;
	localparam logic [7:0] KeyRGui   = 8'hE7;

	class key_event_board;
		localparam int unsigned ShownLimit = 40;

		logic        rep_enable;
		logic [9:0]  first_delay;
		logic [9:0]  floor_period;
		logic [7:0]  held [Slots];
		int unsigned held_n;
		logic [6:0]  mods;
		logic        rep_on;
		logic [7:0]  rep_key;
		logic [9:0]  rep_period;
		logic [9:0]  rep_left;
		out_item_t   due_events [$];
		int unsigned mismatches;
		int unsigned beats_in;
		int unsigned events_checked;
		int unsigned repeats_checked;

		function new();
			rep_enable   = 1'b1;
			first_delay  = 10'd250;
			floor_period = 10'd50;
			foreach (held[i]) held[i] = '0;
			held_n          = 0;
			mods            = '0;
			rep_on          = 1'b0;
			rep_key         = '0;
			rep_period      = '0;
			rep_left        = '0;
			mismatches      = 0;
			beats_in        = 0;
			events_checked  = 0;
			repeats_checked = 0;
		endfunction

		static function logic [6:0] modifier_of(logic [7:0] k);
			case (k)
				KeyLShift: return 7'b000_0001;
				KeyRShift: return 7'b000_0010;
				KeyLAlt:   return 7'b000_0100;
				KeyRAlt:   return 7'b000_1000;
				KeyLCtrl:  return 7'b001_0000;
				KeyRCtrl:  return 7'b010_0000;
				default:   return 7'b000_0000;
			endcase
		endfunction

		static function bit listed(logic [7:0] k, logic [7:0] keys [Slots], int unsigned n);
			for (int unsigned i = 0; i < n; i++)
				if (keys[i] == k) return 1'b1;
			return 1'b0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [9:0] v);
			case (idx)
				REG_REPEAT_ENABLE: rep_enable = v[0];
				REG_INITIAL_DELAY: first_delay = v;
				REG_MIN_INTERVAL:  floor_period = v;
				default: ;
			endcase
		endfunction

		function void add_event(logic [7:0] k, logic rep);
			out_item_t e;
			e.keycode       = k;
			e.modifier_mask = mods;
			e.caps_led      = mods[BitCaps];
			e.is_repeat     = rep;
			e.last_event    = 1'b0;
			due_events.push_back(e);
		endfunction

		function void note_input(in_item_t it);
			logic [7:0]  now [Slots];
			int unsigned n_now;
			int unsigned first;
			int unsigned next_period;
			first = due_events.size();
			beats_in++;
			if (it.action == ActTick) begin
				if (rep_on && rep_enable) begin
					// a countdown of 0 or 1 fires, so a zero delay behaves as one
					if (rep_left <= 10'd1) begin
						add_event(rep_key, 1'b1);
						next_period = (32'(rep_period) * 3) / 4;
						if (next_period < 32'(floor_period)) next_period = 32'(floor_period);
						rep_period = next_period[9:0];
						rep_left   = rep_period;
					end else begin
						rep_left--;
					end
				end
			end else begin
				now   = '{it.key_0, it.key_1, it.key_2, it.key_3, it.key_4, it.key_5};
				n_now = (it.key_count > NKey) ? NKey : it.key_count;
				for (int unsigned i = 0; i < held_n; i++) begin
					if (!listed(held[i], now, n_now)) begin
						mods &= ~modifier_of(held[i]);
						if (rep_on && rep_key == held[i]) rep_on = 1'b0;
					end
				end
				// duplicates in one report each count as a separate press
				for (int unsigned i = 0; i < n_now; i++) begin
					if (!listed(now[i], held, held_n)) begin
						mods |= modifier_of(now[i]);
						if (now[i] == KeyCapsLock) mods[BitCaps] = ~mods[BitCaps];
						if (rep_enable && modifier_of(now[i]) == '0) begin
							rep_on     = 1'b1;
							rep_key    = now[i];
							rep_period = first_delay;
							rep_left   = first_delay;
						end
						add_event(now[i], 1'b0);
					end
				end
				foreach (held[i]) held[i] = (i < n_now) ? now[i] : 8'h00;
				held_n = n_now;
			end
			if (due_events.size() > first) due_events[due_events.size() - 1].last_event = 1'b1;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_events.size() == 0) begin
				mismatches++;
				if (mismatches <= ShownLimit)
					$display("%0t: event with none due: key %h mask %h caps %b rep %b last %b",
						$time, got.keycode, got.modifier_mask, got.caps_led, got.is_repeat,
						got.last_event);
				return;
			end
			want = due_events.pop_front();
			events_checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= ShownLimit)
					$display({"%0t: expected key %h mask %h caps %b rep %b last %b, ",
						"actual key %h mask %h caps %b rep %b last %b"}, $time,
						want.keycode, want.modifier_mask, want.caps_led, want.is_repeat,
						want.last_event, got.keycode, got.modifier_mask, got.caps_led,
						got.is_repeat, got.last_event);
			end else if (want.is_repeat) begin
				repeats_checked++;
			end
		endfunction
	endclass

endpackage

module keyboard_report_diff_typematic_test;
	timeunit 1ns;
	timeprecision 1ps;

	import krdt_pkg::*;
	import krdt_test_pkg::*;

	localparam int          InBits       = $bits(in_item_t);
	localparam int unsigned SettleCycles = 24;
	localparam int unsigned CycleLimit   = 200_000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [9:0] cfg_wdata;

	key_event_board board;
	logic [7:0]     pressed [$];
	int unsigned    tx_idle_pct  = 0;
	int unsigned    rx_stall_pct = 0;
	int unsigned    settings_run = 0;
	int unsigned    cycle_count  = 0;

	keyboard_report_diff_typematic DUT (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.cfg_wr_en, .cfg_index, .cfg_wdata
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// sink side: check every beat, stall at the phase's rate
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) board.check_result(out_data);
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	function automatic in_item_t report_item(logic [2:0] cnt, logic [47:0] keys);
		return in_item_t'({ActReport, cnt, keys});
	endfunction

	function automatic in_item_t tick_item();
		in_item_t it;
		it = in_item_t'(InBits'({$urandom, $urandom}));
		it.action = ActTick;
		return it;
	endfunction

	function automatic logic [7:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return KeyA + 8'($urandom_range(6));
		if (r < 67) return KeyCapsLock;
		if (r < 92) return KeyLCtrl + 8'($urandom_range(7));
		return 8'($urandom);
	endfunction

	// mostly evolve the last report by one release or press; now and then a wild one
	function automatic in_item_t next_report();
		logic [47:0] slots;
		int unsigned cnt;
		int unsigned r;
		slots = 48'({$urandom, $urandom});
		r = $urandom_range(99);
		if (r < 10) begin
			cnt = $urandom_range(7);
			pressed.delete();
			for (int unsigned i = 0; i < cnt && i < Slots; i++)
				pressed.push_back(slots[47 - 8 * i -: 8]);
		end else begin
			if (r < 15)
				pressed.delete();
			else if (pressed.size() != 0 && $urandom_range(99) < 40)
				pressed.delete(int'($urandom_range(pressed.size() - 1)));
			if (pressed.size() < Slots && $urandom_range(99) < 65) begin
				if (pressed.size() != 0 && $urandom_range(99) < 8)
					pressed.push_back(pressed[$urandom_range(pressed.size() - 1)]);
				else
					pressed.push_back(pick_key());
			end
			foreach (pressed[i]) slots[47 - 8 * i -: 8] = pressed[i];
			cnt = pressed.size();
			if (cnt == Slots && $urandom_range(3) == 0) cnt = 7;
		end
		return report_item(3'(cnt), slots);
	endfunction

	task automatic send_beat(input in_item_t item);
		if (tx_idle_pct != 0) begin
			while ($urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_input(item);
	endtask

	task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// drop valid, drain all due events, then let queued no-event inputs finish
	task automatic settle();
		in_valid <= 1'b0;
		while (board.due_events.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [9:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic load_settings(input logic en, input logic [9:0] delay,
			input logic [9:0] floor_ticks);
		logic [9:0] en_word;
		en_word = {9'($urandom), en};
		settle();
		write_reg(REG_REPEAT_ENABLE, en_word);
		write_reg(REG_INITIAL_DELAY, delay);
		write_reg(REG_MIN_INTERVAL, floor_ticks);
		cfg_wr_en <= 1'b0;
		settings_run++;
	endtask

	task automatic run_random(input int unsigned beats, input int unsigned tick_pct);
		int unsigned sent;
		int unsigned burst;
		sent = 0;
		while (sent < beats) begin
			if ($urandom_range(99) < tick_pct) begin
				burst = $urandom_range(1, 4);
				repeat (burst) send_beat(tick_item());
				sent += burst;
			end else begin
				send_beat(next_report());
				sent++;
			end
		end
	endtask

	initial begin
		board = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_REPEAT_ENABLE;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: one press and a few ticks, well short of the first repeat
		send_beat(report_item(3'd1, {KeyA, 40'h0}));
		repeat (4) send_beat(tick_item());
		send_beat(report_item(3'd0, 48'h0));

		load_settings(1'b1, 10'd2, 10'd1);
		send_beat(report_item(3'd0, 48'h0));
		send_beat(report_item(3'd1, {KeyA, 40'h0}));
		repeat (3) send_beat(tick_item());
		send_beat(report_item(3'd3, {KeyA, KeyLShift, KeyRShift, 24'h0}));
		send_beat(report_item(3'd6, {KeyA, KeyLShift, KeyRShift, KeyLAlt, KeyRAlt, KeyLCtrl}));
		// oversized count, GUI key, caps twice in one report, both ends of the id range
		send_beat(report_item(3'd7, {KeyRCtrl, KeyLGui, KeyCapsLock, KeyCapsLock, 8'hFF, 8'h00}));
		repeat (2) send_beat(tick_item());
		send_beat(report_item(3'd1, {KeyRCtrl, 40'hFF_FFFF_FFFF}));
		send_beat(tick_item());
		send_beat(report_item(3'd1, {KeyCapsLock, 40'h0}));
		send_beat(report_item(3'd0, 48'hFFFF_FFFF_FFFF));
		send_beat(report_item(3'd1, {KeyCapsLock, 40'h0}));
		send_beat(report_item(3'd2, {KeyB, KeyB, 32'h0}));
		repeat (2) send_beat(tick_item());
		send_beat(report_item(3'd2, {KeyB, KeyRGui, 32'h0}));
		send_beat(report_item(3'd1, {KeyRGui, 40'h0}));
		send_beat(tick_item());

		load_settings(1'b1, 10'd3, 10'd1);
		set_idling(0, 0);
		run_random(48, 50);

		load_settings(1'b1, 10'd6, 10'd2);
		set_idling(64, 0);
		run_random(48, 55);

		load_settings(1'b1, 10'd1, 10'd1);
		set_idling(0, 64);
		run_random(48, 40);

		load_settings(1'b0, 10'd4, 10'd1);
		set_idling(19, 19);
		run_random(46, 50);

		// largest floor: the first repeat lifts the period to it, later ticks count down
		load_settings(1'b1, 10'd1, 10'd1023);
		set_idling(0, 0);
		send_beat(report_item(3'd1, {KeyB, 40'h0}));
		repeat (4) send_beat(tick_item());
		send_beat(report_item(3'd0, 48'h0));

		load_settings(1'b1, 10'd10, 10'd4);
		set_idling(19, 19);
		run_random(48, 50);

		settle();
		$display("Covered %0d input beats over %0d register settings plus reset defaults.",
			board.beats_in, settings_run);
		$display("Checked %0d key events, %0d of them auto-repeats.",
			board.events_checked, board.repeats_checked);
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
